// ===== hdl/pti_pkg.sv =====
// Shared types and constants of the piecewise table interpolator.
// No dependencies; imported by the controller, the datapath and the top level.
package pti_pkg;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    localparam logic INTERP_STEP   = 1'b0;
    localparam logic INTERP_LINEAR = 1'b1;

    localparam logic REG_INTERP_MODE = 1'b0;
    localparam logic REG_POINT_COUNT = 1'b1;

    localparam logic signed [15:0] ABS_MIN = -16'sd16384;
    localparam logic signed [15:0] ABS_MAX = 16'sd16384;

    localparam int W_W    = 17;  // interval weights
    localparam int PROD_W = 49;  // 32 x 17 signed product
    localparam int NUM_W  = 50;  // sum of two products
    localparam int MAG_W  = 48;  // numerator magnitude, divider width
    localparam int DIV_STEPS = 48;
    localparam int CNT_W  = 6;

    typedef struct packed {
        logic sel_res_v;   // result <= current entry value
        logic sel_res_vl;  // result <= lower neighbor value
        logic save_lo;     // current entry becomes lower neighbor
        logic save_hi;     // current entry is upper neighbor, latch weights
        logic mul1;
        logic mul2;
        logic sum;
        logic absv;
        logic div_step;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic le;      // sample <= entry abscissa
        logic lt;      // sample <  entry abscissa
        logic dl_le0;  // entry abscissa - lower abscissa <= 0
    } t_dp_stat;

endpackage

// ===== hdl/pti_ctrl.sv =====
// Sequencer of the interpolator: table scan, multiply, divide, result strobe.
// Depends on pti_pkg.
module pti_ctrl import pti_pkg::*; #(
    parameter int IW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_mode,
    input  logic          i_interp,
    input  logic [IW-1:0] i_last,
    input  t_dp_stat      i_stat,
    output t_dp_cmd       o_cmd,
    output logic [IW-1:0] o_rd_addr,
    output logic          o_busy,
    output logic          o_done
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FETCH = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_MUL1  = 4'd3;
    localparam logic [3:0] ST_MUL2  = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_ABS   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic             w_first, w_last;

    assign w_first = (r_idx == '0);
    assign w_last  = (r_idx == i_last);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_idx   = '0;
                    n_state = (i_mode == MODE_EVAL) ? ST_FETCH : ST_OUT;
                end
            end
            ST_FETCH: n_state = ST_SCAN;
            ST_SCAN: begin
                priority if (w_first && i_stat.le) begin
                    o_cmd.sel_res_v = 1'b1;
                    n_state = ST_OUT;
                end else if (!w_first && i_interp == INTERP_LINEAR && i_stat.le) begin
                    if (i_stat.dl_le0) begin
                        o_cmd.sel_res_v = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        o_cmd.save_hi = 1'b1;
                        n_state = ST_MUL1;
                    end
                end else if (!w_first && i_interp == INTERP_STEP && i_stat.lt) begin
                    o_cmd.sel_res_vl = 1'b1;
                    n_state = ST_OUT;
                end else if (w_last) begin
                    o_cmd.sel_res_v = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    o_cmd.save_lo = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_FETCH;
                end
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = ST_ABS;
            end
            ST_ABS: begin
                o_cmd.absv = 1'b1;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    assign o_rd_addr = r_idx;
    assign o_busy    = (r_state != ST_IDLE);
    assign o_done    = r_done;

    a_done_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == ST_OUT)
        else $error("result strobe without output state");
    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |=> r_state == ST_IDLE && r_done)
        else $error("output state did not strobe");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_cnt < CNT_W'(DIV_STEPS))
        else $error("divider count overrun");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_idx == i_last) |=> r_state != ST_FETCH)
        else $error("scan went past last breakpoint");

endmodule

// ===== hdl/pti_dpath.sv =====
// Datapath of the interpolator: breakpoint memories, compare, multiply, divide.
// Depends on pti_pkg.
module pti_dpath import pti_pkg::*; #(
    parameter int MAX_POINTS = 16,
    parameter int IW = 4
) (
    input  logic                i_clk,
    input  logic                i_accept,
    input  logic                i_mode,
    input  logic [3:0]          i_point_index,
    input  logic signed [15:0]  i_point_abscissa,
    input  logic signed [31:0]  i_point_value,
    input  logic signed [15:0]  i_sample_x,
    input  logic [IW-1:0]       i_rd_addr,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic signed [31:0]  o_shaped_value,
    output logic                o_status
);

    logic signed [15:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_v [MAX_POINTS];

    logic signed [15:0]     r_rd_x, r_sample, r_xl;
    logic signed [31:0]     r_rd_v, r_vl, r_vh;
    logic signed [W_W-1:0]  r_w1, r_w2;
    logic [15:0]            r_dl;
    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic signed [NUM_W-1:0]  r_num;
    logic                   r_neg;
    logic [MAG_W-1:0]       r_q;
    logic [15:0]            r_rem;
    logic signed [31:0]     r_result;
    logic                   r_status;

    logic                   w_range_bad, w_we;
    logic signed [W_W-1:0]  w_dl;
    logic signed [NUM_W-1:0] w_abs;
    logic [16:0]            w_rem_sh;
    logic                   w_ge;
    logic [31:0]            w_q;

    assign w_range_bad = (i_point_abscissa < ABS_MIN) || (i_point_abscissa > ABS_MAX);
    assign w_we = i_accept && (i_mode == MODE_LOAD) && !w_range_bad
                  && (int'(i_point_index) < MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_x[IW'(i_point_index)] <= i_point_abscissa;
            mem_v[IW'(i_point_index)] <= i_point_value;
        end
        r_rd_x <= mem_x[i_rd_addr];
        r_rd_v <= mem_v[i_rd_addr];
    end

    assign w_dl = W_W'(r_rd_x) - W_W'(r_xl);
    assign o_stat.le     = (r_sample <= r_rd_x);
    assign o_stat.lt     = (r_sample <  r_rd_x);
    assign o_stat.dl_le0 = (w_dl <= 0);

    assign w_abs    = r_num[NUM_W-1] ? -r_num : r_num;
    assign w_rem_sh = {r_rem, r_q[MAG_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dl});
    assign w_q      = r_q[31:0];

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sample <= i_sample_x;
            r_result <= '0;
            r_status <= (i_mode == MODE_LOAD) && w_range_bad;
        end
        if (i_cmd.save_lo) begin
            r_xl <= r_rd_x;
            r_vl <= r_rd_v;
        end
        if (i_cmd.save_hi) begin
            r_vh <= r_rd_v;
            r_w1 <= W_W'(r_rd_x) - W_W'(r_sample);
            r_w2 <= W_W'(r_sample) - W_W'(r_xl);
            r_dl <= w_dl[15:0];
        end
        if (i_cmd.sel_res_v)  r_result <= r_rd_v;
        if (i_cmd.sel_res_vl) r_result <= r_vl;
        if (i_cmd.mul1) r_p1 <= r_vh * r_w2;
        if (i_cmd.mul2) r_p2 <= r_vl * r_w1;
        if (i_cmd.sum)  r_num <= NUM_W'(r_p1) + NUM_W'(r_p2);
        if (i_cmd.absv) begin
            r_neg <= r_num[NUM_W-1];
            r_q   <= w_abs[MAG_W-1:0];
            r_rem <= '0;
        end
        // restoring division, one quotient bit per beat; remainder stays below the interval
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? 16'(w_rem_sh - {1'b0, r_dl}) : w_rem_sh[15:0];
            r_q   <= {r_q[MAG_W-2:0], w_ge};
        end
        if (i_cmd.fin) r_result <= r_neg ? -$signed(w_q) : $signed(w_q);
    end

    assign o_shaped_value = r_result;
    assign o_status       = r_status;

endmodule

// ===== hdl/piecewise_table_interpolator_core.sv =====
// Piecewise table interpolator, top level: APB registers and block wiring.
// Depends on pti_pkg, pti_ctrl, pti_dpath.
//
// Usage:
//   An item is taken when start is high and busy is low. A load item
//   (i_mode = 0) writes breakpoint i_point_index; abscissae outside -1..1
//   are refused with o_status = 1. An evaluate item (i_mode = 1) looks up
//   i_sample_x over the first point_count breakpoints.
//   Each item gives one result on o_shaped_value / o_status, valid for the
//   single cycle in which o_done is high; the receiver cannot stall it.
//   An evaluate item scans at most point_count table entries in order; a
//   linear interpolation then runs two multiplier beats, sum, abs, 48 divider
//   beats and sign fix. The scan reads one table entry at a time through the
//   registered memory port.
//   Items are processed one at a time; busy stays high until o_done.
//   Reset sets interp_mode = 1 (linear) and point_count = 1; table contents
//   are undefined until loaded. Registers: 0x0 interp_mode, 0x4 point_count.
module piecewise_table_interpolator_core import pti_pkg::*; #(
    parameter int MAX_POINTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [3:0]         i_point_index,
    input  logic signed [15:0] i_point_abscissa,
    input  logic signed [31:0] i_point_value,
    input  logic signed [15:0] i_sample_x,
    output logic               o_done,
    output logic signed [31:0] o_shaped_value,
    output logic               o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic       r_interp_mode;
    logic [4:0] r_point_count;
    logic       w_accept, w_cfg_we;
    logic [8:0] w_n;
    logic [IW-1:0] w_last, w_rd_addr;
    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp_mode <= INTERP_LINEAR;
            r_point_count <= 5'd1;
        end else if (w_cfg_we) begin
            if (paddr[2] == REG_INTERP_MODE) r_interp_mode <= pwdata[0];
            else                             r_point_count <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == REG_INTERP_MODE) ? {31'd0, r_interp_mode}
                                                  : {27'd0, r_point_count};

    always_comb begin
        priority if (r_point_count == 5'd0)                  w_n = 9'd1;
        else if (int'(r_point_count) > MAX_POINTS)           w_n = 9'(MAX_POINTS);
        else                                                 w_n = {4'd0, r_point_count};
    end
    assign w_last   = IW'(w_n - 9'd1);
    assign w_accept = start && !busy;

    pti_ctrl #(.IW(IW)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_mode    (i_mode),
        .i_interp  (r_interp_mode),
        .i_last    (w_last),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_rd_addr (w_rd_addr),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    pti_dpath #(.MAX_POINTS(MAX_POINTS), .IW(IW)) u_dpath (
        .i_clk            (i_clk),
        .i_accept         (w_accept),
        .i_mode           (i_mode),
        .i_point_index    (i_point_index),
        .i_point_abscissa (i_point_abscissa),
        .i_point_value    (i_point_value),
        .i_sample_x       (i_sample_x),
        .i_rd_addr        (w_rd_addr),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_shaped_value   (o_shaped_value),
        .o_status         (o_status)
    );

endmodule

// ===== tb/piecewise_table_interpolator_core_tb.sv =====
// Testbench for piecewise_table_interpolator_core: drives load/evaluate items and
// APB register writes, checks each beat against an in-bench table predictor.
// Depends on pti_pkg and the RTL top level only.
`timescale 1ns / 100ps

module piecewise_table_interpolator_core_tb import pti_pkg::*;;

    typedef struct {
        logic               mode;
        logic [3:0]         idx;
        logic signed [15:0] absc;
        logic signed [31:0] val;
        logic signed [15:0] sx;
    } t_item;

    typedef struct {
        logic signed [31:0] value;
        logic               status;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_mode = 1'b0;
    logic [3:0]         i_point_index = '0;
    logic signed [15:0] i_point_abscissa = '0;
    logic signed [31:0] i_point_value = '0;
    logic signed [15:0] i_sample_x = '0;
    logic               o_done;
    logic signed [31:0] o_shaped_value;
    logic               o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    piecewise_table_interpolator_core u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic signed [15:0] abs_tab [16];
    logic signed [31:0] val_tab [16];
    logic               cur_interp;
    logic [4:0]         cur_count;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      errors = 0;
    int      idle_pct = 0;
    int      idle_cnt = 0;
    bit      took = 1'b0;

    function automatic t_result predict_result(t_item it);
        t_result r;
        int n;
        longint s, xl, xh, dl, num;
        r.value = '0;
        r.status = 1'b0;
        if (it.mode == MODE_LOAD) begin
            if (it.absc < ABS_MIN || it.absc > ABS_MAX) begin
                r.status = 1'b1;
            end else begin
                abs_tab[it.idx] = it.absc;
                val_tab[it.idx] = it.val;
            end
            return r;
        end
        n = (cur_count == 0) ? 1 : (cur_count > 16 ? 16 : cur_count);
        s = it.sx;
        if (s <= abs_tab[0]) begin
            r.value = val_tab[0];
            return r;
        end
        for (int i = 1; i < n; i++) begin
            xh = abs_tab[i];
            if (cur_interp == INTERP_STEP) begin
                if (s < xh) begin
                    r.value = val_tab[i-1];
                    return r;
                end
            end else if (s <= xh) begin
                xl = abs_tab[i-1];
                dl = xh - xl;
                if (dl <= 0) begin
                    r.value = val_tab[i];
                end else begin
                    num = longint'(val_tab[i]) * (s - xl) + longint'(val_tab[i-1]) * (xh - s);
                    r.value = 32'(num / dl);
                end
                return r;
            end
        end
        r.value = val_tab[n-1];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        errors++;
    endtask

    // driver: a beat stays on the ports until the edge that takes it
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                t_item it;
                it = pending_items.pop_front();
                expected_results.push_back(predict_result(it));
                i_mode <= it.mode; i_point_index <= it.idx; i_point_abscissa <= it.absc;
                i_point_value <= it.val; i_sample_x <= it.sx;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            took <= start && !busy;
            if (start && !busy) idle_cnt <= 0;
            else if (o_done) idle_cnt <= 0;
            else idle_cnt <= idle_cnt + 1;
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", o_shaped_value, 0);
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (o_shaped_value !== e.value)
                        report_mismatch("shaped_value", o_shaped_value, e.value);
                    if (o_status !== e.status)
                        report_mismatch("status", o_status, e.status);
                end
            end
            if (idle_cnt > 20000) begin
                $display("timeout");
                $display("piecewise_table_interpolator_core test failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {addr, 2'b00}; pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == REG_INTERP_MODE) cur_interp = data[0];
        else cur_count = data[4:0];
    endtask

    function automatic t_item load_item(int idx, int a, int v);
        t_item it;
        it.mode = MODE_LOAD; it.idx = 4'(idx); it.absc = 16'(a); it.val = 32'(v);
        it.sx = 16'($urandom);
        return it;
    endfunction

    function automatic t_item eval_item(int s);
        t_item it;
        it.mode = MODE_EVAL; it.idx = 4'($urandom); it.absc = 16'($urandom);
        it.val = 32'($urandom);
        it.sx = 16'(s);
        return it;
    endfunction

    // strictly increasing abscissae in [-1,1] with random values, sometimes extreme
    task automatic load_table(int n);
        int a;
        int step_max;
        a = -16384 + $urandom_range(0, 2000);
        for (int i = 0; i < n; i++) begin
            int v;
            case ($urandom_range(3))
                0: v = 32'h7fffffff;
                1: v = 32'h80000000;
                default: v = $urandom;
            endcase
            step_max = (16384 - a) / (n - i);
            if (step_max < 1) step_max = 1;
            pending_items.push_back(load_item(i, a, v));
            a = a + $urandom_range(1, step_max);
            if (a > 16384) a = 16384;
        end
    endtask

    // a sample at a loaded abscissa or one off it, hitting exact breakpoints
    function automatic int abs_pick();
        int i;
        i = $urandom_range(0, 15);
        return int'(abs_tab[i]) + $urandom_range(0, 2) - 1;
    endfunction

    initial begin
        int nitems;
        cur_interp = INTERP_LINEAR;
        cur_count = 1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full abscissa range, ends, exact hits, rejects
        pending_items.push_back(load_item(0, -16384, 32'h7fffffff));
        pending_items.push_back(load_item(1, 0, 32'h80000000));
        pending_items.push_back(load_item(15, 16384, 32'h12345678));
        pending_items.push_back(load_item(2, 16385, 5));
        pending_items.push_back(load_item(2, -16385, 5));
        pending_items.push_back(load_item(2, 32767, 5));
        pending_items.push_back(load_item(2, -32768, 5));
        pending_items.push_back(load_item(2, 16384, -1));
        wait_drained();
        apb_write(REG_POINT_COUNT, 3);
        pending_items.push_back(eval_item(-32768));
        pending_items.push_back(eval_item(-16384));
        pending_items.push_back(eval_item(-1));
        pending_items.push_back(eval_item(0));
        pending_items.push_back(eval_item(8192));
        pending_items.push_back(eval_item(16384));
        pending_items.push_back(eval_item(32767));
        wait_drained();
        apb_write(REG_INTERP_MODE, INTERP_STEP);
        pending_items.push_back(eval_item(-16384));
        pending_items.push_back(eval_item(-16383));
        pending_items.push_back(eval_item(0));
        pending_items.push_back(eval_item(16383));
        pending_items.push_back(eval_item(16384));
        pending_items.push_back(eval_item(32767));
        wait_drained();

        // random phases: idle level, mode and count rotate
        for (int ph = 0; ph < 16; ph++) begin
            int cnt;
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 56;
                2: idle_pct = 12;
                default: idle_pct = 56;
            endcase
            cnt = (ph == 0) ? 16 : (ph == 1) ? 1 : (ph == 2) ? 2 : $urandom_range(1, 16);
            apb_write(REG_INTERP_MODE, ph[0] ? INTERP_STEP : INTERP_LINEAR);
            apb_write(REG_POINT_COUNT, cnt);
            load_table(16);
            nitems = 60;
            for (int k = 0; k < nitems; k++) begin
                int r;
                r = $urandom_range(99);
                if (r < 5) pending_items.push_back(load_item($urandom_range(0, 15),
                        $urandom_range(0, 1) ? 16385 + $urandom_range(0, 16382)
                                             : -16385 - $urandom_range(0, 16383), $urandom));
                else if (r < 15) pending_items.push_back(eval_item($urandom));
                else if (r < 25) pending_items.push_back(eval_item(abs_pick()));
                else pending_items.push_back(eval_item($urandom_range(0, 32768) - 16384));
                if (k == 30 && ph == 3) wait_drained();
            end
            wait_drained();
        end
        idle_pct = 0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("piecewise_table_interpolator_core test passed");
        end else begin
            $display("piecewise_table_interpolator_core test failed");
        end
        $finish;
    end

endmodule

// ===== piecewise_table_interpolator_core.f =====
hdl/pti_pkg.sv
hdl/pti_ctrl.sv
hdl/pti_dpath.sv
hdl/piecewise_table_interpolator_core.sv
tb/piecewise_table_interpolator_core_tb.sv
